>>> rtl/core/leb_pkg.sv
`timescale 1ns / 1ps

package leb_pkg;

   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   localparam logic [7:0] RST_LITERAL  = 8'd22;
   localparam logic [7:0] RST_EOF      = 8'd4;
   localparam logic [7:0] RST_ERASE    = 8'd8;
   localparam logic [7:0] RST_WERASE   = 8'd23;
   localparam logic [7:0] RST_KILL     = 8'd21;
   localparam logic [7:0] RST_REPRINT  = 8'd18;
   localparam logic [6:0] RST_CAPACITY = 7'd64;
   localparam logic       RST_STOP_NL  = 1'b1;

   localparam int CSR_AW = 5;

   typedef enum logic [2:0] {
      REG_LITERAL  = 3'd0,
      REG_EOF      = 3'd1,
      REG_ERASE    = 3'd2,
      REG_WERASE   = 3'd3,
      REG_KILL     = 3'd4,
      REG_REPRINT  = 3'd5,
      REG_CAPACITY = 3'd6,
      REG_STOP_NL  = 3'd7
   } leb_reg_type;

   typedef struct packed {
      logic [7:0] literal_char;
      logic [7:0] eof_char;
      logic [7:0] erase_char;
      logic [7:0] word_erase_char;
      logic [7:0] kill_char;
      logic [7:0] reprint_char;
      logic [6:0] capacity;
      logic       stop_after_newline;
   } leb_cfg_type;

   typedef struct packed {
      logic       stored;
      logic [7:0] stored_char;
      logic [5:0] stored_index;
      logic [5:0] line_length;
      logic       bell;
      logic       redisplay;
      logic       reprint;
      logic       done_res;
   } leb_res_type;

   function automatic logic is_gap(input logic [7:0] c);
      return (c == CH_NL) || (c == CH_SP) || (c == CH_TAB);
   endfunction

endpackage

>>> rtl/core/leb_csr.sv
`timescale 1ns / 1ps

module leb_csr
   import leb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output leb_cfg_type       cfg
);

   leb_cfg_type cfg_ff;
   leb_cfg_type cfg_in;
   leb_reg_type reg_sel;
   logic        wr_stb;

   assign reg_sel = leb_reg_type'(paddr[4:2]);
   assign wr_stb  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_sel)
            REG_LITERAL:  cfg_in.literal_char       = pwdata[7:0];
            REG_EOF:      cfg_in.eof_char           = pwdata[7:0];
            REG_ERASE:    cfg_in.erase_char         = pwdata[7:0];
            REG_WERASE:   cfg_in.word_erase_char    = pwdata[7:0];
            REG_KILL:     cfg_in.kill_char          = pwdata[7:0];
            REG_REPRINT:  cfg_in.reprint_char       = pwdata[7:0];
            REG_CAPACITY: cfg_in.capacity           = pwdata[6:0];
            REG_STOP_NL:  cfg_in.stop_after_newline = pwdata[0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_LITERAL:  prdata = {24'd0, cfg_ff.literal_char};
         REG_EOF:      prdata = {24'd0, cfg_ff.eof_char};
         REG_ERASE:    prdata = {24'd0, cfg_ff.erase_char};
         REG_WERASE:   prdata = {24'd0, cfg_ff.word_erase_char};
         REG_KILL:     prdata = {24'd0, cfg_ff.kill_char};
         REG_REPRINT:  prdata = {24'd0, cfg_ff.reprint_char};
         REG_CAPACITY: prdata = {25'd0, cfg_ff.capacity};
         REG_STOP_NL:  prdata = {31'd0, cfg_ff.stop_after_newline};
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.literal_char       <= RST_LITERAL;
         cfg_ff.eof_char           <= RST_EOF;
         cfg_ff.erase_char         <= RST_ERASE;
         cfg_ff.word_erase_char    <= RST_WERASE;
         cfg_ff.kill_char          <= RST_KILL;
         cfg_ff.reprint_char       <= RST_REPRINT;
         cfg_ff.capacity           <= RST_CAPACITY;
         cfg_ff.stop_after_newline <= RST_STOP_NL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/leb_store.sv
`timescale 1ns / 1ps

module leb_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/leb_seq.sv
`timescale 1ns / 1ps

module leb_seq
   import leb_pkg::*;
#(
   parameter int BUF_DEPTH = 64,
   parameter int CNT_W     = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  leb_cfg_type      cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       char_code,
   input  logic             source_end,
   output logic             wr_en,
   output logic [CNT_W-1:0] wr_addr,
   output logic [7:0]       wr_data,
   output logic [CNT_W-1:0] rd_addr,
   input  logic [7:0]       rd_data,
   output leb_res_type      res,
   output logic             res_valid,
   input  logic             res_take
);

   localparam int LW = (CNT_W + 1 > 7) ? CNT_W + 1 : 7;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_GAP    = 6'b000010,
      ST_WORD   = 6'b000100,
      ST_KFIRST = 6'b001000,
      ST_KLINE  = 6'b010000,
      ST_RESP   = 6'b100000
   } leb_state_type;

   leb_state_type    state_ff, state_in;
   leb_state_type    start_state;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             lit_ff, lit_in;
   logic             finished_ff, finished_in;
   leb_res_type      res_ff, res_in;

   logic [CNT_W-1:0] eff_fill;
   logic [CNT_W-1:0] fill_m1;
   logic             eff_lit;
   logic [LW-1:0]    cap_ext;
   logic [LW-1:0]    limit;
   logic             accept;
   logic             do_append;
   logic             do_erase;
   logic             n_lit;
   logic             walk_st;
   logic             rd_gap;
   logic             rd_nl;
   logic             dec;

   // a finished read starts over with an empty line
   assign eff_fill = finished_ff ? '0 : fill_ff;
   assign eff_lit  = lit_ff && !finished_ff;
   assign fill_m1  = fill_ff - CNT_W'(1);

   always_comb begin
      cap_ext = LW'(cfg.capacity);
      if (cap_ext == '0) begin
         cap_ext = LW'(1);
      end else if (cap_ext > LW'(BUF_DEPTH)) begin
         cap_ext = LW'(BUF_DEPTH);
      end
      limit = cap_ext - LW'(1);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // classify the incoming character, first match wins
   always_comb begin
      res_in              = res_ff;
      res_in.stored       = 1'b0;
      res_in.stored_char  = 8'd0;
      res_in.stored_index = 6'd0;
      res_in.line_length  = 6'd0;
      res_in.bell         = 1'b0;
      res_in.redisplay    = 1'b0;
      res_in.reprint      = 1'b0;
      res_in.done_res     = 1'b0;
      n_lit               = eff_lit;
      do_append           = 1'b0;
      do_erase            = 1'b0;
      start_state         = ST_RESP;
      if (source_end) begin
         n_lit           = 1'b0;
         res_in.done_res = 1'b1;
      end else if (eff_lit) begin
         n_lit     = 1'b0;
         do_append = 1'b1;
      end else if (char_code == cfg.literal_char) begin
         n_lit = 1'b1;
      end else if (char_code == cfg.eof_char) begin
         res_in.done_res = 1'b1;
      end else if (char_code == cfg.erase_char) begin
         if (eff_fill != '0) begin
            do_erase         = 1'b1;
            res_in.redisplay = 1'b1;
         end
      end else if (char_code == cfg.word_erase_char) begin
         if (eff_fill != '0) begin
            start_state      = ST_GAP;
            res_in.redisplay = 1'b1;
         end
      end else if (char_code == cfg.kill_char) begin
         if (eff_fill != '0) begin
            start_state      = ST_KFIRST;
            res_in.redisplay = 1'b1;
         end
      end else if (char_code == cfg.reprint_char) begin
         res_in.reprint = 1'b1;
      end else begin
         do_append = 1'b1;
      end
      if (do_append) begin
         if (LW'(eff_fill) >= limit) begin
            res_in.bell = 1'b1;
         end else begin
            res_in.stored       = 1'b1;
            res_in.stored_char  = char_code;
            res_in.stored_index = 6'(eff_fill);
         end
      end
      if (!source_end && cfg.stop_after_newline && char_code == CH_NL) begin
         n_lit           = 1'b0;
         res_in.done_res = 1'b1;
      end
   end

   // walk back one stored character per cycle
   assign walk_st = (state_ff == ST_GAP) || (state_ff == ST_WORD) ||
                    (state_ff == ST_KFIRST) || (state_ff == ST_KLINE);
   assign rd_gap  = is_gap(rd_data);
   assign rd_nl   = (rd_data == CH_NL);
   assign dec     = (state_ff == ST_GAP) || (state_ff == ST_KFIRST) ||
                    ((state_ff == ST_WORD) && !rd_gap) ||
                    ((state_ff == ST_KLINE) && !rd_nl);

   // prefetch the entry that the walk will look at next
   assign rd_addr = walk_st ? (dec ? fill_ff - CNT_W'(2) : fill_m1)
                            : eff_fill - CNT_W'(1);

   assign wr_en   = accept && res_in.stored;
   assign wr_addr = eff_fill;
   assign wr_data = char_code;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      lit_in      = lit_ff;
      finished_in = finished_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = start_state;
               lit_in      = n_lit;
               finished_in = res_in.done_res;
               if (res_in.stored) begin
                  fill_in = eff_fill + CNT_W'(1);
               end else if (do_erase) begin
                  fill_in = eff_fill - CNT_W'(1);
               end else begin
                  fill_in = eff_fill;
               end
            end
         end
         ST_GAP, ST_WORD, ST_KFIRST, ST_KLINE: begin
            if (dec) begin
               fill_in = fill_m1;
               if (fill_m1 == '0) begin
                  state_in = ST_RESP;
               end else if (state_ff == ST_GAP) begin
                  state_in = rd_gap ? ST_GAP : ST_WORD;
               end else if (state_ff == ST_KFIRST) begin
                  state_in = ST_KLINE;
               end
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         lit_ff      <= 1'b0;
         finished_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         lit_ff      <= lit_in;
         finished_ff <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   always_comb begin
      res             = res_ff;
      res.line_length = 6'(fill_ff);
   end

   assign res_valid = (state_ff == ST_RESP);

`ifndef SYNTHESIS
   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      walk_st |-> fill_ff != '0)
      else $error("walk running on an empty line");

   a_walk_step: assert property (@(posedge clock) disable iff (reset)
      walk_st |=> (fill_ff == $past(fill_ff)) || (fill_ff == $past(fill_ff) - CNT_W'(1)))
      else $error("walk removed more than one character in a cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("sequencer idle right after a transfer");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      res_take |=> state_ff == ST_IDLE)
      else $error("sequencer not idle after its result was taken");
`endif

endmodule

>>> rtl/core/line_edit_buffer.sv
// Line edit buffer: edits one text line, one character transfer at a time.
// req channel: req_char_code with req_source_end; a transfer happens when
// req_valid and req_ready are both high. Every request gives exactly one
// rsp transfer: the stored character and its index, the line length and
// the bell, redisplay, reprint and done flags.
// csr port: APB-style, registers at byte address 4*i, pready always high.
// Plain characters and control codes pass from the req transfer through the
// sequencer state register and the output register to rsp_valid; word erase
// and kill first walk back over the text, reading the text memory one entry
// per cycle through its single read port.
// req_ready is high only while no request is being worked on. The next
// request can be taken while the previous result still waits in the output
// register.
// When the receiver stalls, the result holds in the output register and
// the block stalls too once a second result is ready.
// Reset clears the line length, the pending literal and the finished flag
// and loads the default control characters; text memory is not cleared.
`timescale 1ns / 1ps

module line_edit_buffer
   import leb_pkg::*;
#(
   parameter int BUF_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_char_code,
   input  logic              req_source_end,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_stored,
   output logic [7:0]        rsp_stored_char,
   output logic [5:0]        rsp_stored_index,
   output logic [5:0]        rsp_line_length,
   output logic              rsp_bell,
   output logic              rsp_redisplay,
   output logic              rsp_reprint,
   output logic              rsp_done_res,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CNT_W = $clog2(BUF_DEPTH);

   leb_cfg_type      cfg;
   leb_res_type      res;
   leb_res_type      rsp_ff;
   logic             res_valid;
   logic             res_take;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             wr_en;
   logic [CNT_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [CNT_W-1:0] rd_addr;
   logic [7:0]       rd_data;

   leb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   leb_store #(
      .DEPTH (BUF_DEPTH),
      .AW    (CNT_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   leb_seq #(
      .BUF_DEPTH (BUF_DEPTH),
      .CNT_W     (CNT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .char_code  (req_char_code),
      .source_end (req_source_end),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .res        (res),
      .res_valid  (res_valid),
      .res_take   (res_take)
   );

   // output register frees up when empty or drained this cycle
   assign res_take     = res_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign csr_pready       = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_stored       = rsp_ff.stored;
   assign rsp_stored_char  = rsp_ff.stored_char;
   assign rsp_stored_index = rsp_ff.stored_index;
   assign rsp_line_length  = rsp_ff.line_length;
   assign rsp_bell         = rsp_ff.bell;
   assign rsp_redisplay    = rsp_ff.redisplay;
   assign rsp_reprint      = rsp_ff.reprint;
   assign rsp_done_res     = rsp_ff.done_res;

endmodule

>>> dv/line_edit_buffer_tb.sv
`timescale 1ns / 1ps

module line_edit_buffer_tb;
   import leb_pkg::*;

   localparam int DEPTH       = 64;
   localparam int STALL_LIMIT = 3000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 83;
   localparam int MAX_REPORTS = 10;

   typedef enum logic [1:0] {
      ROW_PREDICTED,
      ROW_KNOWN,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [7:0]   chr;
      logic         src_end;
      leb_res_type  res;
      leb_reg_type  reg_id;
      logic [7:0]   val;
   } script_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_char_code = 8'h00;
   logic              req_source_end = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_stored;
   logic [7:0]        rsp_stored_char;
   logic [5:0]        rsp_stored_index;
   logic [5:0]        rsp_line_length;
   logic              rsp_bell;
   logic              rsp_redisplay;
   logic              rsp_reprint;
   logic              rsp_done_res;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   line_edit_buffer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_source_end   (req_source_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_stored       (rsp_stored),
      .rsp_stored_char  (rsp_stored_char),
      .rsp_stored_index (rsp_stored_index),
      .rsp_line_length  (rsp_line_length),
      .rsp_bell         (rsp_bell),
      .rsp_redisplay    (rsp_redisplay),
      .rsp_reprint      (rsp_reprint),
      .rsp_done_res     (rsp_done_res),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // line model
   logic [7:0]  line_text [DEPTH];
   logic [6:0]  line_fill;
   logic        literal_armed;
   logic        line_closed;
   leb_cfg_type cfg_model;

   leb_res_type    edit_results_due [$];
   script_row_type script_rows [$];

   int snd_gap_pct = 0;
   int rcv_gap_pct = 0;
   int stall_cycles = 0;
   int mismatches = 0;
   int items_sent = 0;
   int settings_used = 0;
   int results_seen = 0;
   int stored_seen = 0;
   int bells_seen = 0;
   int edits_seen = 0;
   int reprints_seen = 0;
   int ends_seen = 0;

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_NL || c == CH_SP || c == CH_TAB;
   endfunction

   function automatic leb_res_type edit_step(input logic [7:0] c, input logic src_end);
      leb_res_type r;
      logic        put;
      int          cap;
      r   = '0;
      put = 1'b0;
      cap = cfg_model.capacity;
      if (cap < 1) cap = 1;
      if (cap > DEPTH) cap = DEPTH;
      if (line_closed) begin
         line_fill     = '0;
         literal_armed = 1'b0;
         line_closed   = 1'b0;
      end
      if (src_end) begin
         literal_armed = 1'b0;
         r.done_res    = 1'b1;
      end else if (literal_armed) begin
         literal_armed = 1'b0;
         put           = 1'b1;
      end else if (c == cfg_model.literal_char) begin
         literal_armed = 1'b1;
      end else if (c == cfg_model.eof_char) begin
         r.done_res = 1'b1;
      end else if (c == cfg_model.erase_char) begin
         if (line_fill > 0) begin
            line_fill   = line_fill - 1;
            r.redisplay = 1'b1;
         end
      end else if (c == cfg_model.word_erase_char) begin
         if (line_fill > 0) begin
            while (line_fill > 0 && is_blank(line_text[line_fill - 1]))
               line_fill = line_fill - 1;
            while (line_fill > 0 && !is_blank(line_text[line_fill - 1]))
               line_fill = line_fill - 1;
            r.redisplay = 1'b1;
         end
      end else if (c == cfg_model.kill_char) begin
         if (line_fill > 0) begin
            // a newline right at the end goes before the walk back
            if (line_text[line_fill - 1] == CH_NL) line_fill = line_fill - 1;
            while (line_fill > 0 && line_text[line_fill - 1] != CH_NL)
               line_fill = line_fill - 1;
            r.redisplay = 1'b1;
         end
      end else if (c == cfg_model.reprint_char) begin
         r.reprint = 1'b1;
      end else begin
         put = 1'b1;
      end
      if (put) begin
         if (line_fill >= cap - 1) begin
            r.bell = 1'b1;
         end else begin
            line_text[line_fill[5:0]] = c;
            r.stored       = 1'b1;
            r.stored_char  = c;
            r.stored_index = line_fill[5:0];
            line_fill      = line_fill + 1;
         end
      end
      if (!src_end && cfg_model.stop_after_newline && c == CH_NL) begin
         literal_armed = 1'b0;
         r.done_res    = 1'b1;
      end
      if (r.done_res) line_closed = 1'b1;
      r.line_length = line_fill[5:0];
      return r;
   endfunction

   function automatic leb_res_type known_res(input logic st, input logic [7:0] ch,
                                             input logic [5:0] idx, input logic [5:0] len,
                                             input logic bell, input logic redis,
                                             input logic rep, input logic done);
      leb_res_type r;
      r.stored       = st;
      r.stored_char  = ch;
      r.stored_index = idx;
      r.line_length  = len;
      r.bell         = bell;
      r.redisplay    = redis;
      r.reprint      = rep;
      r.done_res     = done;
      return r;
   endfunction

   function automatic string show_res(input leb_res_type r);
      return $sformatf("st=%0d ch=%02h idx=%0d len=%0d bell=%0d redis=%0d rep=%0d done=%0d",
                       r.stored, r.stored_char, r.stored_index, r.line_length,
                       r.bell, r.redisplay, r.reprint, r.done_res);
   endfunction

   function automatic logic [7:0] reg_mask(input leb_reg_type r);
      case (r)
         REG_CAPACITY: return 8'h7f;
         REG_STOP_NL:  return 8'h01;
         default:      return 8'hff;
      endcase
   endfunction

   function automatic logic [8:0] roll_input(input int end_pct, input int ctrl_pct);
      int         roll;
      logic [7:0] c;
      c    = 8'h61 + 8'($urandom_range(0, 25));
      roll = $urandom_range(0, 99);
      if (roll < end_pct) return {1'b1, 8'($urandom())};
      roll = $urandom_range(0, 99);
      if (roll < ctrl_pct) begin
         case ($urandom_range(0, 7))
            0:       c = cfg_model.literal_char;
            1:       c = cfg_model.eof_char;
            2, 3:    c = cfg_model.erase_char;
            4, 5:    c = cfg_model.word_erase_char;
            6:       c = cfg_model.kill_char;
            default: c = cfg_model.reprint_char;
         endcase
      end else if (roll < ctrl_pct + 12) begin
         case ($urandom_range(0, 3))
            0, 1:    c = CH_SP;
            2:       c = CH_TAB;
            default: c = CH_NL;
         endcase
      end else if (roll < ctrl_pct + 20) begin
         c = 8'($urandom());
      end
      return {1'b0, c};
   endfunction

   task automatic reset_model();
      for (int i = 0; i < DEPTH; i++) line_text[i] = 8'h00;
      line_fill     = '0;
      literal_armed = 1'b0;
      line_closed   = 1'b0;
      cfg_model.literal_char       = RST_LITERAL;
      cfg_model.eof_char           = RST_EOF;
      cfg_model.erase_char         = RST_ERASE;
      cfg_model.word_erase_char    = RST_WERASE;
      cfg_model.kill_char          = RST_KILL;
      cfg_model.reprint_char       = RST_REPRINT;
      cfg_model.capacity           = RST_CAPACITY;
      cfg_model.stop_after_newline = RST_STOP_NL;
   endtask

   task automatic csr_access(input leb_reg_type r, input logic wr, input logic [7:0] v,
                             output logic [31:0] rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= {24'h0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_reg(input leb_reg_type r, input logic [7:0] v);
      logic [31:0] rd;
      logic [7:0]  val;
      val = v & reg_mask(r);
      csr_access(r, 1'b1, val, rd);
      case (r)
         REG_LITERAL:  cfg_model.literal_char       = val;
         REG_EOF:      cfg_model.eof_char           = val;
         REG_ERASE:    cfg_model.erase_char         = val;
         REG_WERASE:   cfg_model.word_erase_char    = val;
         REG_KILL:     cfg_model.kill_char          = val;
         REG_REPRINT:  cfg_model.reprint_char       = val;
         REG_CAPACITY: cfg_model.capacity           = val[6:0];
         REG_STOP_NL:  cfg_model.stop_after_newline = val[0];
         default: ;
      endcase
      csr_access(r, 1'b0, 8'h00, rd);
      if (rd !== {24'h0, val}) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("csr readback %s: exp %08h act %08h", r.name(), {24'h0, val}, rd);
      end
   endtask

   task automatic sender_gap();
      while ($urandom_range(0, 99) < snd_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // valid drops first so it never gets two updates in one step
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (edit_results_due.size() != 0);
   endtask

   task automatic send_char(input logic [7:0] c, input logic src_end, input bit known,
                            input leb_res_type given);
      leb_res_type pred;
      req_valid      <= 1'b1;
      req_char_code  <= c;
      req_source_end <= src_end;
      do @(posedge clock); while (!req_ready);
      pred = edit_step(c, src_end);
      edit_results_due.push_back(known ? given : pred);
      items_sent++;
   endtask

   task automatic add_known(input logic [7:0] c, input logic src_end, input leb_res_type r);
      script_row_type row;
      row.kind    = ROW_KNOWN;
      row.chr     = c;
      row.src_end = src_end;
      row.res     = r;
      row.reg_id  = REG_LITERAL;
      row.val     = 8'h00;
      script_rows.push_back(row);
   endtask

   task automatic add_predicted(input logic [7:0] c);
      script_row_type row;
      row.kind    = ROW_PREDICTED;
      row.chr     = c;
      row.src_end = 1'b0;
      row.res     = '0;
      row.reg_id  = REG_LITERAL;
      row.val     = 8'h00;
      script_rows.push_back(row);
   endtask

   task automatic add_csr(input leb_reg_type r, input logic [7:0] v);
      script_row_type row;
      row.kind    = ROW_CSR;
      row.chr     = 8'h00;
      row.src_end = 1'b0;
      row.res     = '0;
      row.reg_id  = r;
      row.val     = v;
      script_rows.push_back(row);
   endtask

   task automatic build_script();
      leb_res_type none;
      none = '0;
      // empty line: erase, word erase and kill do nothing
      add_known(RST_ERASE,  1'b0, none);
      add_known(RST_WERASE, 1'b0, none);
      add_known(RST_KILL,   1'b0, none);
      add_known(8'h61, 1'b0, known_res(1, 8'h61, 0, 1, 0, 0, 0, 0));
      add_known(8'hff, 1'b0, known_res(1, 8'hff, 1, 2, 0, 0, 0, 0));
      add_known(CH_SP, 1'b0, known_res(1, CH_SP, 2, 3, 0, 0, 0, 0));
      add_known(8'h62, 1'b0, known_res(1, 8'h62, 3, 4, 0, 0, 0, 0));
      add_known(RST_WERASE, 1'b0, known_res(0, 0, 0, 3, 0, 1, 0, 0));
      add_known(RST_WERASE, 1'b0, known_res(0, 0, 0, 0, 0, 1, 0, 0));
      // literal prefix stores the eof character
      add_known(RST_LITERAL, 1'b0, none);
      add_known(RST_EOF, 1'b0, known_res(1, RST_EOF, 0, 1, 0, 0, 0, 0));
      add_known(RST_REPRINT, 1'b0, known_res(0, 0, 0, 1, 0, 0, 1, 0));
      add_known(RST_ERASE, 1'b0, known_res(0, 0, 0, 0, 0, 1, 0, 0));
      add_known(8'h78, 1'b0, known_res(1, 8'h78, 0, 1, 0, 0, 0, 0));
      // source end wins over a pending literal
      add_known(RST_LITERAL, 1'b0, known_res(0, 0, 0, 1, 0, 0, 0, 0));
      add_known(8'hff, 1'b1, known_res(0, 0, 0, 1, 0, 0, 0, 1));
      add_known(8'h79, 1'b0, known_res(1, 8'h79, 0, 1, 0, 0, 0, 0));
      add_known(RST_EOF, 1'b0, known_res(0, 0, 0, 1, 0, 0, 0, 1));
      add_known(CH_NL, 1'b0, known_res(1, CH_NL, 0, 1, 0, 0, 0, 1));
      add_csr(REG_STOP_NL, 8'h00);
      add_csr(REG_CAPACITY, 8'h04);
      add_known(8'h61, 1'b0, known_res(1, 8'h61, 0, 1, 0, 0, 0, 0));
      add_known(CH_NL, 1'b0, known_res(1, CH_NL, 1, 2, 0, 0, 0, 0));
      add_known(8'h62, 1'b0, known_res(1, 8'h62, 2, 3, 0, 0, 0, 0));
      add_known(8'h63, 1'b0, known_res(0, 0, 0, 3, 1, 0, 0, 0));
      // kill stops at the newline, the next kill takes the newline too
      add_known(RST_KILL, 1'b0, known_res(0, 0, 0, 2, 0, 1, 0, 0));
      add_known(RST_KILL, 1'b0, known_res(0, 0, 0, 0, 0, 1, 0, 0));
      add_predicted(8'h64);
      add_predicted(8'h65);
      add_predicted(8'h66);
      add_predicted(8'h67);
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   always @(posedge clock) begin
      leb_res_type got;
      leb_res_type want;
      string       diff;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.stored       = rsp_stored;
            got.stored_char  = rsp_stored_char;
            got.stored_index = rsp_stored_index;
            got.line_length  = rsp_line_length;
            got.bell         = rsp_bell;
            got.redisplay    = rsp_redisplay;
            got.reprint      = rsp_reprint;
            got.done_res     = rsp_done_res;
            results_seen++;
            stored_seen   += got.stored;
            bells_seen    += got.bell;
            edits_seen    += got.redisplay;
            reprints_seen += got.reprint;
            ends_seen     += got.done_res;
            if (edit_results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result transfer with nothing expected: %s",
                           $realtime, show_res(got));
            end else begin
               want = edit_results_due.pop_front();
               diff = "";
               if (got.stored !== want.stored)             diff = {diff, " stored"};
               if (got.stored_char !== want.stored_char)   diff = {diff, " stored_char"};
               if (got.stored_index !== want.stored_index) diff = {diff, " stored_index"};
               if (got.line_length !== want.line_length)   diff = {diff, " line_length"};
               if (got.bell !== want.bell)                 diff = {diff, " bell"};
               if (got.redisplay !== want.redisplay)       diff = {diff, " redisplay"};
               if (got.reprint !== want.reprint)           diff = {diff, " reprint"};
               if (got.done_res !== want.done_res)         diff = {diff, " done_res"};
               if (diff != "") begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: result %0d differs in%s", $realtime, results_seen, diff);
                     $display("   exp %s", show_res(want));
                     $display("   act %s", show_res(got));
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rcv_gap_pct);
      end
   end

   initial begin
      do @(posedge clock); while (stall_cycles < STALL_LIMIT);
      $display("no transfer for %0d cycles, %0d results still due",
               STALL_LIMIT, edit_results_due.size());
      $display("line_edit_buffer_tb NOT OK");
      $finish;
   end

   initial begin
      logic [7:0]  setting [8];
      logic [8:0]  pick;
      int          end_pct;
      int          ctrl_pct;
      leb_res_type none;
      none = '0;
      reset_model();
      build_script();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      snd_gap_pct = 38;
      rcv_gap_pct = 81;
      foreach (script_rows[i]) begin
         case (script_rows[i].kind)
            ROW_CSR: begin
               drain_results();
               program_reg(script_rows[i].reg_id, script_rows[i].val);
               settings_used++;
            end
            ROW_KNOWN: begin
               sender_gap();
               send_char(script_rows[i].chr, script_rows[i].src_end, 1'b1,
                         script_rows[i].res);
            end
            default: begin
               sender_gap();
               send_char(script_rows[i].chr, script_rows[i].src_end, 1'b0, none);
            end
         endcase
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 3)
            0: begin
               snd_gap_pct = 38;
               rcv_gap_pct = 81;
            end
            1: begin
               snd_gap_pct = 81;
               rcv_gap_pct = 38;
            end
            default: begin
               snd_gap_pct = 0;
               rcv_gap_pct = 0;
            end
         endcase
         setting[REG_LITERAL]  = RST_LITERAL;
         setting[REG_EOF]      = RST_EOF;
         setting[REG_ERASE]    = RST_ERASE;
         setting[REG_WERASE]   = RST_WERASE;
         setting[REG_KILL]     = RST_KILL;
         setting[REG_REPRINT]  = RST_REPRINT;
         setting[REG_CAPACITY] = {1'b0, RST_CAPACITY};
         setting[REG_STOP_NL]  = {7'h0, RST_STOP_NL};
         case (phase)
            0: begin
               setting[REG_LITERAL]  = 8'h00;
               setting[REG_EOF]      = 8'hff;
               setting[REG_ERASE]    = 8'h7f;
               setting[REG_CAPACITY] = 8'h7f;
               setting[REG_STOP_NL]  = 8'h00;
            end
            1: setting[REG_CAPACITY] = 8'h00;
            2: begin
               setting[REG_CAPACITY] = 8'h01;
               setting[REG_STOP_NL]  = 8'h00;
            end
            6: begin
               setting[REG_LITERAL]  = 8'hff;
               setting[REG_EOF]      = 8'h00;
               setting[REG_CAPACITY] = 8'd65;
               setting[REG_STOP_NL]  = 8'h00;
            end
            8: ;
            default: begin
               setting[REG_LITERAL] = 8'($urandom());
               setting[REG_EOF]     = 8'($urandom());
               setting[REG_ERASE]   = 8'($urandom());
               setting[REG_WERASE]  = 8'($urandom());
               setting[REG_KILL]    = 8'($urandom());
               setting[REG_REPRINT] = 8'($urandom());
               case (phase)
                  3:       setting[REG_CAPACITY] = 8'd64;
                  4:       setting[REG_CAPACITY] = 8'd2;
                  5:       setting[REG_CAPACITY] = 8'($urandom_range(3, 63));
                  default: setting[REG_CAPACITY] = 8'($urandom_range(1, 127));
               endcase
               setting[REG_STOP_NL] = (phase == 3) ? 8'h00 : 8'($urandom_range(0, 1));
            end
         endcase
         // every third phase keeps lines long so the buffer fills up
         end_pct  = (phase % 3 == 0) ? 0 : 2;
         ctrl_pct = (phase % 3 == 0) ? 5 : 14;

         drain_results();
         for (int i = 0; i < 8; i++) program_reg(leb_reg_type'(i), setting[i]);
         settings_used++;

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) drain_results();
            sender_gap();
            pick = roll_input(end_pct, ctrl_pct);
            send_char(pick[7:0], pick[8], 1'b0, none);
         end
      end

      drain_results();
      repeat (DEPTH + 16) @(posedge clock);
      $display("sent %0d characters over %0d register settings, %0d results checked",
               items_sent, settings_used, results_seen);
      $display("stored %0d, bells %0d, edits %0d, reprints %0d, line ends %0d, mismatches %0d",
               stored_seen, bells_seen, edits_seen, reprints_seen, ends_seen, mismatches);
      if (mismatches == 0 && edit_results_due.size() == 0)
         $display("line_edit_buffer_tb OK");
      else
         $display("line_edit_buffer_tb NOT OK");
      $finish;
   end

endmodule
